// ===== sv/assert_macros.svh =====
// Assertion macros shared by the execute unit modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m");
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("%m");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== sv/mieb_pkg.sv =====
// Package with codes, types and constants of the execute unit.
`timescale 1ns / 1ps
`default_nettype none
package mieb_pkg;
    localparam logic [2:0] OC_SEQ     = 3'd0;
    localparam logic [2:0] OC_TAKEN   = 3'd1;
    localparam logic [2:0] OC_NULLIFY = 3'd2;
    localparam logic [2:0] OC_BREAK   = 3'd3;
    localparam logic [2:0] OC_UNKNOWN = 3'd4;
    localparam logic [2:0] OC_OUTSIDE = 3'd5;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_BEQL    = 6'h14;
    localparam logic [5:0] OP_BNEL    = 6'h15;
    localparam logic [5:0] OP_BLEZL   = 6'h16;
    localparam logic [5:0] OP_BGTZL   = 6'h17;

    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV   = 6'h1A;
    localparam logic [5:0] FN_DIVU  = 6'h1B;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic        is_signed;
        logic [31:0] a;
        logic [31:0] b;
    } t_md_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] hi;
        logic [31:0] lo;
    } t_md_rsp;
endpackage
`default_nettype wire

// ===== sv/mieb_muldiv.sv =====
// Iterative multiply and divide unit, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mieb_muldiv import mieb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_md_req i_req,
    output t_md_rsp      o_rsp
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_div, n_div;
    logic        r_negq, n_negq;
    logic        r_negr, n_negr;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_b, n_b;
    logic [31:0] ma, mb;
    logic [32:0] sum;
    logic [32:0] diff;
    logic [63:0] res;

    always_comb begin
        ma = (i_req.is_signed && i_req.a[31]) ? 32'(0 - i_req.a) : i_req.a;
        mb = (i_req.is_signed && i_req.b[31]) ? 32'(0 - i_req.b) : i_req.b;
        sum = {1'b0, r_acc[63:32]} + (r_acc[0] ? {1'b0, r_b} : 33'd0);
        diff = {r_acc[63:31]} - {1'b0, r_b};
        n_busy = r_busy; n_done = 1'b0; n_div = r_div; n_negq = r_negq;
        n_negr = r_negr; n_cnt = r_cnt; n_acc = r_acc; n_b = r_b;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1; n_div = i_req.is_div; n_cnt = 6'd32;
            n_b = mb; n_acc = {32'd0, ma};
            n_negq = i_req.is_signed && (i_req.a[31] != i_req.b[31]);
            n_negr = i_req.is_signed && i_req.a[31];
        end else if (r_busy) begin
            if (r_div) begin
                if (!diff[32]) n_acc = {diff[31:0], r_acc[30:0], 1'b1};
                else           n_acc = {r_acc[62:0], 1'b0};
            end else begin
                n_acc = {sum, r_acc[31:1]};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
        if (r_div) begin
            res[31:0]  = r_negq ? 32'(0 - r_acc[31:0]) : r_acc[31:0];
            res[63:32] = r_negr ? 32'(0 - r_acc[63:32]) : r_acc[63:32];
        end else begin
            res = r_negq ? 64'(0 - r_acc) : r_acc;
        end
        o_rsp.busy = r_busy;
        o_rsp.done = r_done;
        o_rsp.hi = res[63:32];
        o_rsp.lo = res[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_div <= n_div; r_negq <= n_negq; r_negr <= n_negr;
        r_cnt <= n_cnt; r_acc <= n_acc; r_b <= n_b;
    end

    `ASSERT_IMPL(a_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy))
    `ASSERT_IMPL(a_not_both, i_clk, i_rst_n, !(r_done && r_busy))
    `ASSERT_IMPL(a_cnt_live, i_clk, i_rst_n, r_busy |-> (r_cnt != 6'd0))
endmodule
`default_nettype wire

// ===== sv/mieb_regfile.sv =====
// Register file memory with two synchronous read ports and valid bits.
`timescale 1ns / 1ps
`default_nettype none
module mieb_regfile import mieb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [4:0]  i_ra,
    input  wire logic [4:0]  i_rb,
    input  wire logic        i_we,
    input  wire logic [4:0]  i_wa,
    input  wire logic [31:0] i_wd,
    output logic [31:0]      o_da,
    output logic [31:0]      o_db
);
    logic [31:0] r_mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_qa, r_qb;
    logic        r_va, r_vb;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_wa] <= i_wd;
        r_qa <= r_mem[i_ra];
        r_qb <= r_mem[i_rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0; r_va <= 1'b0; r_vb <= 1'b0;
        end else begin
            if (i_we) r_vld[i_wa] <= 1'b1;
            r_va <= r_vld[i_ra] && (i_ra != 5'd0);
            r_vb <= r_vld[i_rb] && (i_rb != 5'd0);
        end
    end

    assign o_da = r_va ? r_qa : 32'd0;
    assign o_db = r_vb ? r_qb : 32'd0;
endmodule
`default_nettype wire

// ===== sv/mips_integer_execute_branch_unit.sv =====
// Top level of the MIPS32 SPECIAL, REGIMM and branch-likely execute unit.
// Each instruction passes through accept, register file read, then execute and
// write back with the result placed in the output register; the register file's
// synchronous read is why the read step is needed. MULT, MULTU, DIV and DIVU also
// wait on the shared bit-serial multiply and divide unit. A new item is accepted only
// once the previous result has been taken, or in the cycle in which it is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mips_integer_execute_branch_unit import mieb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // instruction [31:0], slot_address [63:32]
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // outcome [2:0], branch_target [34:3], write_enable [35], write_index [40:36],
    // write_value [72:41], hi_value [104:73], lo_value [136:105], zero [143:137]
    output logic [143:0]     m_axis_tdata
);
    typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_MD} t_state;
    t_state      r_st;
    logic [31:0] r_ins, r_slot, r_hi, r_lo;
    logic        r_ov;
    logic [143:0] r_out;
    logic [31:0] a, b;
    t_md_req     md_req;
    t_md_rsp     md_rsp;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [31:0] bt, link;
    logic [2:0]  oc;
    logic [31:0] tgt, wv, nhi, nlo;
    logic        we, ismd;
    logic [4:0]  wi;
    logic [1:0]  cond;
    logic        fire, fin;

    assign op = r_ins[31:26]; assign rs = r_ins[25:21]; assign rt = r_ins[20:16];
    assign rd = r_ins[15:11]; assign sa = r_ins[10:6];  assign fn = r_ins[5:0];
    assign bt = r_slot + {{14{r_ins[15]}}, r_ins[15:0], 2'b00};
    assign link = r_slot + 32'd4;
    assign ismd = (op == OP_SPECIAL) && (fn[5:2] == 4'b0110);

    always_comb begin
        oc = OC_SEQ; tgt = 32'd0; we = 1'b0; wi = rd; wv = 32'd0;
        nhi = r_hi; nlo = r_lo; cond = 2'b00;
        unique case (op)
            OP_SPECIAL: begin
                unique case (fn)
                    6'h00: begin we = 1'b1; wv = b << sa; end
                    6'h02: begin we = 1'b1; wv = b >> sa; end
                    6'h03: begin we = 1'b1; wv = 32'($signed(b) >>> sa); end
                    6'h04: begin we = 1'b1; wv = b << a[4:0]; end
                    6'h06: begin we = 1'b1; wv = b >> a[4:0]; end
                    6'h07: begin we = 1'b1; wv = 32'($signed(b) >>> a[4:0]); end
                    6'h08: begin oc = OC_TAKEN; tgt = a; end
                    6'h09: begin oc = OC_TAKEN; tgt = a; we = 1'b1; wv = link; end
                    6'h0A: begin we = (b == 32'd0); wv = a; end
                    6'h0B: begin we = (b != 32'd0); wv = a; end
                    6'h0C, 6'h0F, 6'h30, 6'h31, 6'h32, 6'h33, 6'h34, 6'h36: ;
                    6'h0D: oc = OC_BREAK;
                    6'h10: begin we = 1'b1; wv = r_hi; end
                    6'h11: nhi = a;
                    6'h12: begin we = 1'b1; wv = r_lo; end
                    6'h13: nlo = a;
                    FN_MULT, FN_MULTU: begin nhi = md_rsp.hi; nlo = md_rsp.lo; end
                    FN_DIV, FN_DIVU: if (b != 32'd0) begin
                        nhi = md_rsp.hi; nlo = md_rsp.lo;
                    end
                    6'h20, 6'h21: begin we = 1'b1; wv = a + b; end
                    6'h22, 6'h23: begin we = 1'b1; wv = a - b; end
                    6'h24: begin we = 1'b1; wv = a & b; end
                    6'h25: begin we = 1'b1; wv = a | b; end
                    6'h26: begin we = 1'b1; wv = a ^ b; end
                    6'h27: begin we = 1'b1; wv = ~(a | b); end
                    6'h2A: begin we = 1'b1; wv = {31'd0, $signed(a) < $signed(b)}; end
                    6'h2B: begin we = 1'b1; wv = {31'd0, a < b}; end
                    default: oc = OC_UNKNOWN;
                endcase
            end
            OP_REGIMM: begin
                unique case (rt)
                    5'h00: if (a[31]) begin oc = OC_TAKEN; tgt = bt; end
                    5'h01: if (!a[31]) begin oc = OC_TAKEN; tgt = bt; end
                    5'h02: cond = {1'b1, a[31]};
                    5'h03: cond = {1'b1, !a[31]};
                    5'h10, 5'h11: begin
                        we = 1'b1; wi = 5'd31; wv = link;
                        if (a[31] ^ rt[0]) begin oc = OC_TAKEN; tgt = bt; end
                    end
                    default: oc = OC_UNKNOWN;
                endcase
            end
            OP_BEQL:  cond = {1'b1, a == b};
            OP_BNEL:  cond = {1'b1, a != b};
            OP_BLEZL: cond = {1'b1, a[31] || (a == 32'd0)};
            OP_BGTZL: cond = {1'b1, !a[31] && (a != 32'd0)};
            default:  oc = OC_OUTSIDE;
        endcase
        if (cond == 2'b11) begin
            oc = OC_TAKEN; tgt = bt;
        end else if (cond == 2'b10) begin
            oc = OC_NULLIFY; tgt = link;
        end
        if (!we || wi == 5'd0) begin
            we = 1'b0; wi = 5'd0; wv = 32'd0;
        end
    end

    assign fin = (r_st == S_EXEC && !ismd) || (r_st == S_MD && md_rsp.done);
    assign s_axis_tready = (r_st == S_IDLE) && (!r_ov || m_axis_tready);
    assign fire = s_axis_tvalid && s_axis_tready;
    assign md_req.start = (r_st == S_EXEC) && ismd;
    assign md_req.is_div = fn[1];
    assign md_req.is_signed = !fn[0];
    assign md_req.a = a;
    assign md_req.b = b;

    mieb_regfile u_rf (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_ra(rs), .i_rb(rt),
        .i_we(fin && we), .i_wa(wi), .i_wd(wv),
        .o_da(a), .o_db(b)
    );

    mieb_muldiv u_md (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(md_req), .o_rsp(md_rsp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0; r_hi <= 32'd0; r_lo <= 32'd0;
        end else begin
            unique case (r_st)
                S_IDLE: if (fire) r_st <= S_READ;
                S_READ: r_st <= S_EXEC;
                S_EXEC: r_st <= ismd ? S_MD : S_IDLE;
                S_MD:   if (md_rsp.done) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
            if (fin) begin
                r_ov <= 1'b1; r_hi <= nhi; r_lo <= nlo;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
        if (fire) begin
            r_ins <= s_axis_tdata[31:0]; r_slot <= s_axis_tdata[63:32];
        end
        if (fin) r_out <= {7'd0, nlo, nhi, wv, wi, we, tgt, oc};
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_out;

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, fire |=> (r_st == S_READ))
    `ASSERT_IMPL(a_fin_room, i_clk, i_rst_n, fin |-> (!r_ov || m_axis_tready || r_st == S_MD))
    `ASSERT_IMPL(a_md_once, i_clk, i_rst_n, md_req.start |=> (r_st == S_MD))
endmodule
`default_nettype wire
